// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TQSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TQSD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define TQSD_ASSERT(lbl, prop, msg)
`define TQSD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/tqsd_pkg.sv =====
// types and constants of the timeout queue server dispatcher
package tqsd_pkg;

	localparam int unsigned EntryW = 64;
	localparam logic [15:0] ServiceTimeReset = 16'd30;
	localparam logic [3:0]  ServersReset     = 4'd3;

	typedef enum logic [0:0] {
		CFG_SERVICE_TIME = 1'b0,
		CFG_SERVERS      = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_QUEUED    = 3'd0,
		KIND_DROPPED   = 3'd1,
		KIND_ABANDONED = 3'd2,
		KIND_NO_SERVER = 3'd3,
		KIND_SERVED    = 3'd4,
		KIND_EMPTY     = 3'd5
	} kind_t;

	typedef enum logic [0:0] {
		CMD_ARRIVAL = 1'b0,
		CMD_CALL    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] event_time;
		logic [15:0] client_id;
		logic [15:0] tolerance;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now;
		logic [15:0] request_id;
		logic [31:0] waited;
		logic [2:0]  server_index;
		logic [31:0] finish_time;
		logic [31:0] next_free;
		logic [31:0] served_total;
		logic [47:0] wait_sum;
		logic        last;
	} out_item_t;

	// queue entry layout
	typedef struct packed {
		logic [15:0] tolerance;
		logic [31:0] arrival;
		logic [15:0] id;
	} entry_t;

endpackage

// ===== rtl/tqsd_ram.sv =====
// generic single write port ram with registered read
module tqsd_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/tqsd_front.sv =====
// front end: accepts transactions into a two entry command queue
module tqsd_front
	import tqsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output logic     cmd_valid,
	output in_item_t cmd_item,
	input  logic     cmd_pop
);
	in_item_t   ent_q [2];
	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_item  = ent_q[rd_q];

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_item;
		end
	end
endmodule

// ===== rtl/tqsd_back.sv =====
// back end: request queue, server scan, statistics and result register
`include "assert_macros.svh"
module tqsd_back
	import tqsd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 32,
	parameter int unsigned MAX_SERVERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  in_item_t    cmd_item,
	output logic        cmd_pop,
	input  logic [15:0] service_time,
	input  logic [3:0]  servers_in_use,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);
	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int unsigned CW = $clog2(MAX_SERVERS + 1);
	localparam logic [NW-1:0] DepthC = NW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LastAddr = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] MaxC = CW'(MAX_SERVERS);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_ARRIVE   = 6'b000010,
		ST_CALL     = 6'b000100,
		ST_CHECK    = 6'b001000,
		ST_SCAN     = 6'b010000,
		ST_DISPATCH = 6'b100000
	} state_t;

	state_t          state_q;
	in_item_t        cmd_q;
	logic [31:0]     cur_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [NW-1:0]   count_q;
	logic [31:0]     free_q [MAX_SERVERS];
	logic [31:0]     served_q;
	logic [47:0]     wsum_q;
	logic [31:0]     waited_q;
	logic [SW-1:0]   best_q;
	logic [31:0]     best_val_q;
	logic [CW-1:0]   scan_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic            out_ok;
	logic            emit;
	out_item_t       emit_item;
	logic            ram_we;
	logic            ram_re;
	logic [EntryW-1:0] ram_rdata;
	entry_t          head_ent;
	logic [31:0]     waited_now;
	logic            too_late;
	logic [CW-1:0]   n_act;
	logic [31:0]     scan_val;
	logic [32:0]     fin_sum;
	logic [31:0]     fin;
	logic [48:0]     wsum_sum;
	logic [47:0]     wsum_next;
	logic [31:0]     served_next;
	logic            full;
	logic            can_serve;

	assign out_ok     = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign out_item   = out_q;
	assign full       = (count_q >= DepthC);
	assign head_ent   = entry_t'(ram_rdata);
	assign waited_now = cur_q - head_ent.arrival;
	assign too_late   = (waited_now > {16'd0, head_ent.tolerance});
	assign scan_val   = free_q[scan_q[SW-1:0]];
	assign can_serve  = (cur_q >= best_val_q);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;

	// active server count, clamped to the built range
	always_comb begin
		if (servers_in_use == 4'd0) begin
			n_act = CW'(1);
		end else if ({28'd0, servers_in_use} > 32'(MAX_SERVERS)) begin
			n_act = MaxC;
		end else begin
			n_act = CW'(servers_in_use);
		end
	end

	// saturating finish time and statistics
	assign fin_sum     = {1'b0, cur_q} + {17'd0, service_time};
	assign fin         = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
	assign served_next = (served_q == 32'hFFFF_FFFF) ? served_q : served_q + 32'd1;
	assign wsum_sum    = {1'b0, wsum_q} + {17'd0, waited_q};
	assign wsum_next   = wsum_sum[48] ? 48'hFFFF_FFFF_FFFF : wsum_sum[47:0];

	// queue memory
	assign ram_we = (state_q == ST_ARRIVE) && out_ok && !full;
	assign ram_re = (state_q == ST_CALL) && (count_q != '0);

	tqsd_ram #(
		.WIDTH(EntryW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({cmd_q.tolerance, cmd_q.event_time, cmd_q.client_id}),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// result selection
	always_comb begin
		emit = 1'b0;
		emit_item = '0;
		emit_item.now = cur_q;
		emit_item.served_total = served_q;
		emit_item.wait_sum = wsum_q;
		case (state_q)
			ST_ARRIVE: begin
				emit = out_ok;
				emit_item.kind = full ? KIND_DROPPED : KIND_QUEUED;
				emit_item.request_id = cmd_q.client_id;
				emit_item.last = 1'b1;
			end
			ST_CALL: begin
				emit = out_ok && (count_q == '0);
				emit_item.kind = KIND_EMPTY;
				emit_item.last = 1'b1;
			end
			ST_CHECK: begin
				emit = out_ok && too_late;
				emit_item.kind = KIND_ABANDONED;
				emit_item.request_id = head_ent.id;
				emit_item.waited = waited_now;
			end
			ST_DISPATCH: begin
				emit = out_ok;
				emit_item.request_id = head_ent.id;
				emit_item.last = 1'b1;
				if (can_serve) begin
					emit_item.kind = KIND_SERVED;
					emit_item.waited = waited_q;
					emit_item.server_index = 3'(best_q);
					emit_item.finish_time = fin;
					emit_item.served_total = served_next;
					emit_item.wait_sum = wsum_next;
				end else begin
					emit_item.kind = KIND_NO_SERVER;
					emit_item.next_free = best_val_q;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ok) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
	end

	// sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			served_q <= '0;
			wsum_q   <= '0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				free_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd_item.event_time > cur_q) begin
							cur_q <= cmd_item.event_time;
						end
						state_q <= (cmd_item.cmd == CMD_CALL) ? ST_CALL : ST_ARRIVE;
					end
				end
				ST_ARRIVE: begin
					if (out_ok) begin
						if (!full) begin
							tail_q  <= (tail_q == LastAddr) ? '0 : tail_q + AW'(1);
							count_q <= count_q + NW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CALL: begin
					if (count_q != '0) begin
						state_q <= ST_CHECK;
					end else if (out_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (too_late) begin
						if (out_ok) begin
							head_q  <= (head_q == LastAddr) ? '0 : head_q + AW'(1);
							count_q <= count_q - NW'(1);
							state_q <= ST_CALL;
						end
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_q >= n_act) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					if (out_ok) begin
						if (can_serve) begin
							free_q[best_q] <= fin;
							served_q <= served_next;
							wsum_q   <= wsum_next;
							head_q   <= (head_q == LastAddr) ? '0 : head_q + AW'(1);
							count_q  <= count_q - NW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item latch and server scan datapath
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_item;
		end
		if (state_q == ST_CHECK) begin
			waited_q   <= waited_now;
			best_q     <= '0;
			best_val_q <= free_q[0];
			scan_q     <= CW'(1);
		end else if ((state_q == ST_SCAN) && (scan_q < n_act)) begin
			if (scan_val < best_val_q) begin
				best_q     <= scan_q[SW-1:0];
				best_val_q <= scan_val;
			end
			scan_q <= scan_q + CW'(1);
		end
	end

	`TQSD_ASSERT(a_count_bound, count_q <= DepthC, "queue count above depth")
	`TQSD_ASSERT_NEXT(a_served_mono, 1'b1, served_q >= $past(served_q), "served count fell")
	`TQSD_ASSERT(a_emit_needs_room, emit |-> out_ok, "result produced while output blocked")
	`TQSD_ASSERT_NEXT(a_pop_leaves_idle, cmd_pop, state_q != ST_IDLE, "command popped without work")
endmodule

// ===== rtl/timeout_queue_server_dispatcher_top.sv =====
// Request queue dispatched to the earliest free server, with timeout drop.
// Input channel in_valid/in_stall/in_item carries arrivals (cmd 0) and
// calls (cmd 1); output channel out_valid/out_stall/out_item carries results.
// A transaction moves when valid is high and stall is low at a clock edge.
// The front end buffers up to two input transactions; the back end works
// them off one at a time and owns the request queue ram.
// An arrival gives one result, queued or dropped, from the ARRIVE state.
// A call does a ram read and a check per abandoned request, then a scan over
// the active server free times and a dispatch of the head request;
// a call on an empty queue gives an empty result.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong only while the block is idle.
// Reset (arst_n low) empties queue and command buffer and clears time, server
// free times and statistics; the queue ram holds no valid data after reset
// and needs no clearing pass.
// When out_stall is high while a result is held, the result register holds; the back end waits, and
// once the command buffer is full in_stall rises.
module timeout_queue_server_dispatcher_top
	import tqsd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 32,
	parameter int unsigned MAX_SERVERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic        cmd_valid;
	in_item_t    cmd_item;
	logic        cmd_pop;
	logic [15:0] service_time_q;
	logic [3:0]  servers_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_time_q <= ServiceTimeReset;
			servers_q      <= ServersReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERVICE_TIME: service_time_q <= cfg_data;
				CFG_SERVERS:      servers_q <= cfg_data[3:0];
				default:          servers_q <= servers_q;
			endcase
		end
	end

	tqsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd_item (cmd_item),
		.cmd_pop  (cmd_pop)
	);

	tqsd_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_SERVERS(MAX_SERVERS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_item      (cmd_item),
		.cmd_pop       (cmd_pop),
		.service_time  (service_time_q),
		.servers_in_use(servers_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_item      (out_item)
	);
endmodule
